// ===== hdl/edge_level_interrupt_controller_assert.svh =====
// Assertion macros shared by the interrupt controller RTL.
`ifndef EDGE_LEVEL_INTERRUPT_CONTROLLER_ASSERT_SVH
`define EDGE_LEVEL_INTERRUPT_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ELIC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Same-cycle implication outside reset.
`define ELIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define ELIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ELIC_ASSERT(label, clk, rst_n, prop)
`define ELIC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ELIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/elic_pkg.sv =====
// Package: codes, constants and helpers of the interrupt controller.
`default_nettype none
package elic_pkg;

    // Transaction kinds
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_LINE  = 2'd2;

    // Register selects
    localparam logic [1:0] REG_EVENTS = 2'd0;
    localparam logic [1:0] REG_MASK   = 2'd1;
    localparam logic [1:0] REG_CLEAR  = 2'd2;
    localparam logic [1:0] REG_LEVELS = 2'd3;

    // Mask bit 31 selects emulated mode; raw bit 7 requests a full clear
    localparam int          MODE_BIT   = 31;
    localparam int          RAW_CLEAR  = 7;
    localparam logic [31:0] CLEAR_MASK = 32'h7FFF_FFFF;

    typedef logic [31:0] word_t;

    // Bus byte lanes are reversed
    function automatic word_t swap_bytes(input word_t v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/elic_if.sv =====
// Handshake interfaces for the request and response channels.
`default_nettype none
interface elic_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
    logic [4:0]  line_index;
    logic        line_level;

    modport source (output valid, action, reg_select, write_data, line_index, line_level,
                    input ready);
    modport sink   (input valid, action, reg_select, write_data, line_index, line_level,
                    output ready);
endinterface

interface elic_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        cpu_irq;

    modport source (output valid, read_data, cpu_irq, input ready);
    modport sink   (input valid, read_data, cpu_irq, output ready);
endinterface
`default_nettype wire

// ===== hdl/edge_level_interrupt_controller.sv =====
// 32-line interrupt controller with event, mask and level registers.
//
// Usage: one request channel (cmd) carries register reads, register writes
// and interrupt line changes; one response channel (rsp) returns exactly one
// transaction per request, holding the byte-swapped read data (zero for
// anything but a read) and the CPU interrupt state after the request.
// A request accepted at a clock edge has its response valid from the next cycle.
// Throughput: one request per cycle while rsp.ready is high, set by the single
// response register; the state update is a few bitwise operations on the current
// register values, so consecutive requests see each other's effects at once.
// Stall: cmd.ready is high whenever the response register is empty or is
// being taken in the same cycle, so a stalled receiver stops new requests
// after one response is held; the held response does not change.
// Reset: rst_n clears the event, mask and level words, the CPU latch and
// the response valid flag. There is no clearing pass.
`default_nettype none
`include "edge_level_interrupt_controller_assert.svh"
module edge_level_interrupt_controller (
    input  wire logic     clk,
    input  wire logic     rst_n,
    elic_cmd_if.sink      cmd,
    elic_rsp_if.source    rsp
);

    elic_pkg::word_t event_reg, event_next;
    elic_pkg::word_t mask_reg,  mask_next;
    elic_pkg::word_t level_reg, level_next;
    logic            latch_reg, latch_next;
    logic            rsp_valid_reg;
    elic_pkg::word_t rdata_reg, rdata_next;
    logic            irq_reg;

    logic            accept;
    elic_pkg::word_t line_bit;
    elic_pkg::word_t swapped;
    elic_pkg::word_t ev_tmp;
    logic            mode;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign line_bit  = elic_pkg::word_t'(1) << cmd.line_index;
    assign swapped   = elic_pkg::swap_bytes(cmd.write_data);
    assign mode      = mask_reg[elic_pkg::MODE_BIT];

    // Next state and response data for the current request
    always_comb
    begin
        event_next = event_reg;
        mask_next  = mask_reg;
        level_next = level_reg;
        latch_next = latch_reg;
        rdata_next = '0;
        ev_tmp     = event_reg;
        case (cmd.action)
            elic_pkg::ACT_READ:
            begin
                unique case (cmd.reg_select)
                    elic_pkg::REG_EVENTS: rdata_next = elic_pkg::swap_bytes(event_reg);
                    elic_pkg::REG_MASK:   rdata_next = elic_pkg::swap_bytes(mask_reg);
                    elic_pkg::REG_LEVELS: rdata_next = elic_pkg::swap_bytes(level_reg);
                    default:              rdata_next = '0;
                endcase
            end
            elic_pkg::ACT_WRITE:
            begin
                unique case (cmd.reg_select)
                    elic_pkg::REG_MASK: mask_next = swapped;
                    elic_pkg::REG_CLEAR:
                    begin
                        // full clear when emulated and raw bit 7 set, else selective (bit 31 kept)
                        if (mode && cmd.write_data[elic_pkg::RAW_CLEAR])
                            ev_tmp = '0;
                        else
                            ev_tmp = event_reg & ~(swapped & elic_pkg::CLEAR_MASK);
                        event_next = ev_tmp;
                        if (ev_tmp == '0)
                            latch_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            elic_pkg::ACT_LINE:
            begin
                // native mode: rising edge sets the bit, else clears it; emulated: any report sets
                if (mode || (cmd.line_level && ((level_reg & line_bit) == '0)))
                    ev_tmp = event_reg | line_bit;
                else
                    ev_tmp = event_reg & ~line_bit;
                ev_tmp     = ev_tmp & mask_reg;
                event_next = ev_tmp;
                level_next = cmd.line_level ? (level_reg | line_bit) : (level_reg & ~line_bit);
                if (ev_tmp != '0)
                    latch_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_reg <= '0;
            mask_reg  <= '0;
            level_reg <= '0;
            latch_reg <= 1'b0;
        end
        else if (accept)
        begin
            event_reg <= event_next;
            mask_reg  <= mask_next;
            level_reg <= level_next;
            latch_reg <= latch_next;
        end
    end

    // Response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= latch_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rdata_reg;
    assign rsp.cpu_irq   = irq_reg;

    // Checks
    `ELIC_ASSERT_NEXT(a_irq_matches_latch, clk, rst_n, accept, rsp.cpu_irq == latch_reg)
    `ELIC_ASSERT_NEXT(a_clear_drops_latch, clk, rst_n,
        accept && cmd.action == elic_pkg::ACT_WRITE && cmd.reg_select == elic_pkg::REG_CLEAR,
        event_reg != '0 || !latch_reg)
    `ELIC_ASSERT_IMPL(a_latch_rise_on_line, clk, rst_n, $rose(latch_reg),
        $past(accept) && $past(cmd.action) == elic_pkg::ACT_LINE)
    `ELIC_ASSERT_NEXT(a_levels_only_on_line, clk, rst_n,
        !(accept && cmd.action == elic_pkg::ACT_LINE), $stable(level_reg))

endmodule
`default_nettype wire
